// ----- hdl/orsrch_pkg.sv -----
`default_nettype none
package orsrch_pkg;

   localparam int CODE_BITS = 64;
   localparam int CRC_DATA_BITS = 56;
   localparam logic [7:0] CRC_POLY = 8'h8C;
   localparam logic [7:0] DEVICE_LIMIT_RESET = 8'd8;
   localparam logic [6:0] BIT_POSITION_RESET = 7'd1;
   localparam int RSP_MAX = 3;

   localparam logic [1:0] MODE_RESTART = 2'd0;
   localparam logic [1:0] MODE_PASS = 2'd1;
   localparam logic [1:0] MODE_PAIR = 2'd2;

   localparam logic [1:0] KIND_DIRECTION = 2'd0;
   localparam logic [1:0] KIND_FOUND = 2'd1;
   localparam logic [1:0] KIND_CRC_FAIL = 2'd2;
   localparam logic [1:0] KIND_FINISHED = 2'd3;

   typedef struct packed {
      logic [1:0] mode;
      logic       presence;
      logic       true_bit;
      logic       complement_bit;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        direction;
      logic [63:0] rom_code;
      logic [7:0]  found_count;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]        count;
      rsp_type [RSP_MAX-1:0] item;
   } rsp_push_type;

   typedef logic [CRC_DATA_BITS-1:0][7:0] crc_cols_type;

   // CRC contribution of each single data bit; the CRC is linear with zero init
   function automatic crc_cols_type crc_cols_f();
      crc_cols_type cols;
      logic [7:0]   crc;
      logic         mix;
      for (int i = 0; i < CRC_DATA_BITS; i++) begin
         crc = '0;
         for (int j = 0; j < CRC_DATA_BITS; j++) begin
            mix = crc[0] ^ (i == j);
            crc = crc >> 1;
            if (mix) begin
               crc = crc ^ CRC_POLY;
            end
         end
         cols[i] = crc;
      end
      return cols;
   endfunction

   localparam crc_cols_type CRC_COLS = crc_cols_f();

   function automatic logic [7:0] crc_low(input logic [CRC_DATA_BITS-1:0] data);
      logic [7:0] crc;
      crc = '0;
      for (int i = 0; i < CRC_DATA_BITS; i++) begin
         if (data[i]) begin
            crc = crc ^ CRC_COLS[i];
         end
      end
      return crc;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/orsrch_rsp_queue.sv -----
`default_nettype none
module orsrch_rsp_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire orsrch_pkg::rsp_push_type push,
   output logic                       room,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output orsrch_pkg::rsp_type        rsp_data
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   orsrch_pkg::rsp_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign rsp_valid = count_ff != '0;
   assign rsp_data = entries_ff[rd_ptr_ff];
   assign pop = rsp_valid && rsp_ready;
   assign room = count_ff <= CNT_W'(DEPTH - orsrch_pkg::RSP_MAX);

   always_comb begin
      wr_ptr_in = PTR_W'(wr_ptr_ff + PTR_W'(push.count));
      rd_ptr_in = PTR_W'(rd_ptr_ff + PTR_W'(pop));
      count_in = CNT_W'(count_ff + CNT_W'(push.count) - CNT_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < orsrch_pkg::RSP_MAX; j++) begin
         if (j < int'(push.count)) begin
            entries_ff[PTR_W'(wr_ptr_ff + PTR_W'(j))] <= push.item[j];
         end
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("response queue count above depth");

   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> room)
      else $error("response push without room");

   a_pop_advance: assert property (@(posedge clock) disable iff (reset)
      pop |=> rd_ptr_ff == PTR_W'($past(rd_ptr_ff) + PTR_W'(1)))
      else $error("read pointer did not advance on transfer");
`endif

endmodule
`default_nettype wire

// ----- hdl/onewire_rom_search_engine_top.sv -----
// Channel  Ports                          Direction  Carries
// req      req_valid/req_ready/req_data   in         mode, presence, true/complement bit
// rsp      rsp_valid/rsp_ready/rsp_data   out        kind, direction, rom_code, count, last
// csr      csr_valid/csr_ready/csr_data   in         device_limit (always ready)
//
// An accepted item is registered, then decided when the queue has room; its
// results enter a four-entry result queue and leave one per cycle while
// rsp_ready is high. Sustained rate is one item per cycle while items give
// at most one result and results are taken; a pass end gives up to three,
// and every item waits in the input stage until the queue has room for three
// results. Reset is synchronous: search state clears, device_limit goes to 8.
`default_nettype none
module onewire_rom_search_engine_top (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire orsrch_pkg::req_type req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output orsrch_pkg::rsp_type      rsp_data,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [7:0]          csr_data
);

   logic                in_valid_ff, in_valid_in;
   orsrch_pkg::req_type in_item_ff;
   logic [7:0]          limit_ff;
   logic [63:0]         code_ff, code_in;
   logic [6:0]          last_fork_ff, last_fork_in;
   logic [6:0]          zero_fork_ff, zero_fork_in;
   logic [6:0]          bit_pos_ff, bit_pos_in;
   logic [7:0]          found_ff, found_in;
   logic                done_ff, done_in;
   logic                active_ff, active_in;
   logic                room;
   logic                fire;
   orsrch_pkg::rsp_push_type rsp_push;

   assign csr_ready = 1'b1;
   assign fire = in_valid_ff && room;
   assign req_ready = !in_valid_ff || fire;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= orsrch_pkg::DEVICE_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_data;
      end
   end

   always_comb begin
      logic [6:0]  pos;
      logic [5:0]  idx;
      logic        dir;
      logic        good;
      logic        end_now;
      logic [7:0]  cnt_v;
      logic [63:0] code_v;
      logic [6:0]  nz_v;
      logic [1:0]  slot;

      code_in = code_ff;
      last_fork_in = last_fork_ff;
      zero_fork_in = zero_fork_ff;
      bit_pos_in = bit_pos_ff;
      found_in = found_ff;
      done_in = done_ff;
      active_in = active_ff;
      rsp_push = '0;
      pos = bit_pos_ff;
      idx = 6'(bit_pos_ff - 7'd1);
      dir = 1'b0;
      good = 1'b0;
      end_now = 1'b0;
      cnt_v = found_ff;
      code_v = code_ff;
      nz_v = zero_fork_ff;
      slot = 2'd0;

      if (fire) begin
         unique case (in_item_ff.mode)
            orsrch_pkg::MODE_RESTART: begin
               code_in = '0;
               last_fork_in = '0;
               zero_fork_in = '0;
               bit_pos_in = orsrch_pkg::BIT_POSITION_RESET;
               found_in = '0;
               done_in = 1'b0;
               active_in = 1'b0;
            end
            orsrch_pkg::MODE_PASS: begin
               if (done_ff || found_ff >= limit_ff || !in_item_ff.presence) begin
                  done_in = 1'b1;
                  active_in = 1'b0;
                  rsp_push.count = 2'd1;
                  rsp_push.item[0] = '{kind: orsrch_pkg::KIND_FINISHED, direction: 1'b0,
                                       rom_code: '0, found_count: found_ff, last: 1'b0};
               end else begin
                  active_in = 1'b1;
                  bit_pos_in = orsrch_pkg::BIT_POSITION_RESET;
                  zero_fork_in = '0;
               end
            end
            orsrch_pkg::MODE_PAIR: begin
               if (active_ff) begin
                  if (in_item_ff.true_bit && in_item_ff.complement_bit) begin
                     end_now = 1'b1;
                  end else begin
                     if (in_item_ff.true_bit != in_item_ff.complement_bit) begin
                        dir = in_item_ff.true_bit;
                     end else begin
                        priority if (pos == last_fork_ff) begin
                           dir = 1'b1;
                        end else if (pos > last_fork_ff) begin
                           dir = 1'b0;
                        end else begin
                           dir = code_ff[idx];
                        end
                        if (!dir) begin
                           nz_v = pos;
                        end
                     end
                     code_v[idx] = dir;
                     rsp_push.item[0] = '{kind: orsrch_pkg::KIND_DIRECTION, direction: dir,
                                          rom_code: '0, found_count: found_ff, last: 1'b0};
                     slot = 2'd1;
                     end_now = pos == 7'(orsrch_pkg::CODE_BITS);
                     bit_pos_in = 7'(pos + 7'd1);
                  end
                  if (end_now) begin
                     good = orsrch_pkg::crc_low(code_v[orsrch_pkg::CRC_DATA_BITS-1:0])
                            == code_v[63:56];
                     if (good && found_ff != 8'hFF) begin
                        cnt_v = 8'(found_ff + 8'd1);
                     end
                     rsp_push.item[slot] = '{kind: good ? orsrch_pkg::KIND_FOUND
                                                        : orsrch_pkg::KIND_CRC_FAIL,
                                             direction: 1'b0, rom_code: code_v,
                                             found_count: cnt_v, last: 1'b0};
                     slot = 2'(slot + 2'd1);
                     active_in = 1'b0;
                     bit_pos_in = orsrch_pkg::BIT_POSITION_RESET;
                     last_fork_in = nz_v;
                     if (nz_v == '0 || cnt_v >= limit_ff) begin
                        done_in = 1'b1;
                        rsp_push.item[slot] = '{kind: orsrch_pkg::KIND_FINISHED,
                                                direction: 1'b0, rom_code: '0,
                                                found_count: cnt_v, last: 1'b0};
                        slot = 2'(slot + 2'd1);
                     end
                  end
                  code_in = code_v;
                  zero_fork_in = nz_v;
                  found_in = cnt_v;
                  rsp_push.count = slot;
               end
            end
            default: begin
            end
         endcase
         if (rsp_push.count != 2'd0) begin
            rsp_push.item[2'(rsp_push.count - 2'd1)].last = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff <= '0;
         last_fork_ff <= '0;
         zero_fork_ff <= '0;
         bit_pos_ff <= orsrch_pkg::BIT_POSITION_RESET;
         found_ff <= '0;
         done_ff <= 1'b0;
         active_ff <= 1'b0;
      end else begin
         code_ff <= code_in;
         last_fork_ff <= last_fork_in;
         zero_fork_ff <= zero_fork_in;
         bit_pos_ff <= bit_pos_in;
         found_ff <= found_in;
         done_ff <= done_in;
         active_ff <= active_in;
      end
   end

   orsrch_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !active_ff)
      else $error("pass active after search done");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      bit_pos_ff != '0 && bit_pos_ff <= 7'(orsrch_pkg::CODE_BITS))
      else $error("bit position out of range");

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      fire && in_item_ff.mode != orsrch_pkg::MODE_RESTART
      |=> found_ff >= $past(found_ff))
      else $error("device count dropped without restart");
`endif

endmodule
`default_nettype wire
